### rtl/fmsp_pkg.sv
package fmsp_pkg;

   localparam int CHIP_COUNT_DEF = 2;
   localparam int SLOW_DIV_DEF   = 4;

   localparam logic [1:0] OP_ADDR = 2'd0;
   localparam logic [1:0] OP_DATA = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_DUAL   = 2'd1;
   localparam logic [1:0] MODE_EXT    = 2'd2;
   localparam logic [1:0] MODE_CTRL   = 2'd3;

   localparam logic [15:0] PORT_CTRL_ADDR = 16'h038a;
   localparam logic [15:0] PORT_CTRL_DATA = 16'h038b;
   localparam logic [7:0]  CTRL_ID        = 8'h70;
   localparam logic [7:0]  CTRL_BASE      = 8'h71;
   localparam logic [7:0]  CTRL_ON        = 8'hff;
   localparam logic [7:0]  CTRL_OFF       = 8'hfe;
   localparam logic [7:0]  IDX_LEFT       = 8'h09;
   localparam logic [7:0]  IDX_RIGHT      = 8'h0a;
   localparam logic [7:0]  IDX_ID         = 8'h00;
   localparam logic [7:0]  IDX_BASE       = 8'h15;
   localparam logic [7:0]  STATUS_ID      = 8'h06;

   localparam logic [0:0] CSR_MODE  = 1'b0;
   localparam logic [0:0] CSR_MIXER = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] port_address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic       synth_write;
      logic [8:0] synth_register;
      logic [7:0] synth_value;
      logic [7:0] read_data;
      logic       volume_update;
      logic [4:0] left_volume;
      logic [4:0] right_volume;
      logic       last_result;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  mode;
      logic        mixer;
      logic        dual_both;
      logic        dual_idx;
      logic [15:0] port;
      logic [7:0]  data;
   } cmd_type;

endpackage

### rtl/fmsp_front.sv
module fmsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fmsp_pkg::req_type req_data,
   input  logic [1:0]        mode,
   input  logic              mixer,
   output logic              q_valid,
   input  logic              q_ready,
   output fmsp_pkg::cmd_type q_data
);

   // two-entry queue
   fmsp_pkg::cmd_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   fmsp_pkg::cmd_type cmd;
   logic push, pop;

   always_comb begin
      cmd.opcode    = req_data.opcode;
      cmd.mode      = mode;
      cmd.mixer     = mixer;
      cmd.port      = req_data.port_address;
      cmd.data      = req_data.write_data;
      cmd.dual_both = req_data.port_address[3];
      cmd.dual_idx  = req_data.port_address[1];
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid & req_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid & q_ready;
   assign q_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= cmd;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overfill");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !req_ready) else $error("ready when full");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !q_valid) else $error("valid when empty");

endmodule

### rtl/fmsp_back.sv
module fmsp_back #(
   parameter int CHIP_COUNT = fmsp_pkg::CHIP_COUNT_DEF,
   parameter int SLOW_DIV   = fmsp_pkg::SLOW_DIV_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  fmsp_pkg::cmd_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fmsp_pkg::rsp_type rsp_data
);

   localparam int PW = (SLOW_DIV > 1) ? $clog2(SLOW_DIV) : 1;

   logic [8:0] naddr_ff;
   logic [7:0] daddr_ff [2];
   logic       cact_ff;
   logic [7:0] cidx_ff, lvol_ff, rvol_ff;
   logic [7:0] pre_ff [4];
   logic [7:0] cnt_ff [4];
   logic [3:0] run_ff, msk_ff, ovf_ff;
   logic [PW-1:0] phase_ff;
   logic       second_ff;       // second half of a dual write pending
   logic       ovalid_ff;
   fmsp_pkg::rsp_type odata_ff;

   logic [8:0] naddr_in;
   logic [7:0] daddr_in [2];
   logic       cact_in;
   logic [7:0] cidx_in, lvol_in, rvol_in;
   logic [7:0] pre_in [4];
   logic [7:0] cnt_in [4];
   logic [3:0] run_in, msk_in, ovf_in;
   logic [PW-1:0] phase_in;
   logic       second_in;
   fmsp_pkg::rsp_type r;
   logic       fire, done;

   assign fire = q_valid & (~ovalid_ff | rsp_ready);
   assign q_ready = fire & done;
   assign rsp_valid = ovalid_ff;
   assign rsp_data = odata_ff;

   function automatic logic [7:0] status(input logic [3:0] ov, input logic b);
      logic [7:0] s;
      s = 8'h00;
      if (ov[{b, 1'b0}]) s = s | 8'hc0;
      if (ov[{b, 1'b1}]) s = s | 8'ha0;
      return s;
   endfunction

   always_comb begin
      logic       idx, tb, last, isw, slow;
      logic [7:0] reg8, v;
      logic [8:0] nreg;
      logic [7:0] sb;
      naddr_in = naddr_ff; daddr_in = daddr_ff; cact_in = cact_ff;
      cidx_in = cidx_ff; lvol_in = lvol_ff; rvol_in = rvol_ff;
      pre_in = pre_ff; cnt_in = cnt_ff; run_in = run_ff; msk_in = msk_ff;
      ovf_in = ovf_ff; phase_in = phase_ff; second_in = second_ff;
      r = '0;
      done = 1'b1;
      idx = 1'b0; tb = 1'b0; reg8 = 8'h00; v = q_data.data; nreg = 9'h000;
      isw = 1'b0; sb = 8'h00; slow = 1'b0;
      case (q_data.opcode)
         fmsp_pkg::OP_ADDR: begin
            if (q_data.mode == fmsp_pkg::MODE_SINGLE) naddr_in = {1'b0, q_data.data};
            else if (q_data.mode == fmsp_pkg::MODE_DUAL) begin
               if (!q_data.dual_both) daddr_in[q_data.dual_idx] = q_data.data;
               else begin
                  daddr_in[0] = q_data.data;
                  daddr_in[1] = q_data.data;
               end
            end else begin
               if (q_data.mode == fmsp_pkg::MODE_CTRL
                   && q_data.port == fmsp_pkg::PORT_CTRL_ADDR
                   && (q_data.data == fmsp_pkg::CTRL_ON || q_data.data == fmsp_pkg::CTRL_OFF
                       || cact_ff)) begin
                  if (q_data.data == fmsp_pkg::CTRL_ON) cact_in = 1'b1;
                  else if (q_data.data == fmsp_pkg::CTRL_OFF) cact_in = 1'b0;
                  else cidx_in = q_data.data;
               end else naddr_in = {q_data.port[1], q_data.data};
            end
         end
         fmsp_pkg::OP_DATA: begin
            if (q_data.mode == fmsp_pkg::MODE_DUAL) begin
               idx = q_data.dual_both ? second_ff : q_data.dual_idx;
               tb = (CHIP_COUNT > 1) ? idx : 1'b0;
               reg8 = daddr_ff[idx];
               if (q_data.dual_both && !second_ff) begin
                  done = 1'b0;
                  second_in = 1'b1;
               end else second_in = 1'b0;
               if (reg8 >= 8'he0) v = v & 8'h03;
               if (reg8 == 8'h05) isw = 1'b0;
               else if (reg8 == 8'h02 || reg8 == 8'h03 || reg8 == 8'h04) isw = 1'b0;
               else begin
                  isw = 1'b1;
                  if (reg8 >= 8'hc0 && reg8 <= 8'hc8)
                     v = {(idx ? 4'ha : 4'h5), v[3:0]};
               end
               nreg = {idx, reg8};
               if (reg8 == 8'h05) reg8 = 8'h00;
            end else if (q_data.mode == fmsp_pkg::MODE_CTRL
                         && q_data.port == fmsp_pkg::PORT_CTRL_DATA && cact_ff) begin
               if (cidx_ff == fmsp_pkg::IDX_LEFT || cidx_ff == fmsp_pkg::IDX_RIGHT) begin
                  if (cidx_ff == fmsp_pkg::IDX_LEFT) lvol_in = v; else rvol_in = v;
                  if (q_data.mixer) begin
                     r.volume_update = 1'b1;
                     r.left_volume = lvol_in[4:0];
                     r.right_volume = rvol_in[4:0];
                  end
               end
            end else begin
               nreg = naddr_ff;
               tb = 1'b0;
               if (naddr_ff[8] == 1'b0 && (naddr_ff[7:0] == 8'h02
                   || naddr_ff[7:0] == 8'h03 || naddr_ff[7:0] == 8'h04)) begin
                  reg8 = naddr_ff[7:0];
               end else isw = 1'b1;
            end
            // timer register writes
            if (reg8 == 8'h02) pre_in[{tb, 1'b0}] = v;
            else if (reg8 == 8'h03) pre_in[{tb, 1'b1}] = v;
            else if (reg8 == 8'h04) begin
               if (v[7]) begin
                  ovf_in[{tb, 1'b0}] = 1'b0;
                  ovf_in[{tb, 1'b1}] = 1'b0;
               end else begin
                  if (v[0]) begin
                     if (!run_ff[{tb, 1'b0}]) cnt_in[{tb, 1'b0}] = pre_ff[{tb, 1'b0}];
                     run_in[{tb, 1'b0}] = 1'b1;
                  end else run_in[{tb, 1'b0}] = 1'b0;
                  msk_in[{tb, 1'b0}] = v[6];
                  if (v[6]) ovf_in[{tb, 1'b0}] = 1'b0;
                  if (v[1]) begin
                     if (!run_ff[{tb, 1'b1}]) cnt_in[{tb, 1'b1}] = pre_ff[{tb, 1'b1}];
                     run_in[{tb, 1'b1}] = 1'b1;
                  end else run_in[{tb, 1'b1}] = 1'b0;
                  msk_in[{tb, 1'b1}] = v[5];
                  if (v[5]) ovf_in[{tb, 1'b1}] = 1'b0;
               end
            end
            if (isw) begin
               r.synth_write = 1'b1;
               r.synth_register = nreg;
               r.synth_value = v;
            end
         end
         fmsp_pkg::OP_READ: begin
            if (q_data.mode == fmsp_pkg::MODE_SINGLE)
               sb = (q_data.port[1:0] != 2'b00) ? 8'hff : status(ovf_ff, 1'b0) | fmsp_pkg::STATUS_ID;
            else if (q_data.mode == fmsp_pkg::MODE_DUAL)
               sb = q_data.port[0] ? 8'hff
                  : status(ovf_ff, (CHIP_COUNT > 1) ? q_data.port[1] : 1'b0)
                    | fmsp_pkg::STATUS_ID;
            else if (q_data.mode == fmsp_pkg::MODE_CTRL && cact_ff
                     && q_data.port == fmsp_pkg::PORT_CTRL_ADDR) sb = 8'h00;
            else if (q_data.mode == fmsp_pkg::MODE_CTRL && cact_ff
                     && q_data.port == fmsp_pkg::PORT_CTRL_DATA) begin
               case (cidx_ff)
                  fmsp_pkg::IDX_ID:    sb = fmsp_pkg::CTRL_ID;
                  fmsp_pkg::IDX_LEFT:  sb = lvol_ff;
                  fmsp_pkg::IDX_RIGHT: sb = rvol_ff;
                  fmsp_pkg::IDX_BASE:  sb = fmsp_pkg::CTRL_BASE;
                  default:             sb = 8'hff;
               endcase
            end else sb = (q_data.port[1:0] != 2'b00) ? 8'hff : status(ovf_ff, 1'b0);
            r.read_data = sb;
         end
         default: begin
            if (32'(phase_ff) + 1 >= SLOW_DIV) begin
               slow = 1'b1;
               phase_in = '0;
            end else phase_in = phase_ff + PW'(1);
            for (int t = 0; t < 4; t++) begin
               if ((t / 2) < CHIP_COUNT && (t % 2 == 0 || slow) && run_ff[t]) begin
                  if (cnt_ff[t] == 8'hff) begin
                     cnt_in[t] = pre_ff[t];
                     if (!msk_ff[t]) ovf_in[t] = 1'b1;
                  end else cnt_in[t] = cnt_ff[t] + 8'd1;
               end
            end
         end
      endcase
      last = done;
      r.last_result = last;
   end

   always_ff @(posedge clock) begin
      if (fire) odata_ff <= r;
      if (reset) begin
         naddr_ff <= '0; daddr_ff[0] <= '0; daddr_ff[1] <= '0;
         cact_ff <= 1'b0; cidx_ff <= '0; lvol_ff <= 8'hff; rvol_ff <= 8'hff;
         for (int t = 0; t < 4; t++) begin
            pre_ff[t] <= '0;
            cnt_ff[t] <= '0;
         end
         run_ff <= '0; msk_ff <= '0; ovf_ff <= '0; phase_ff <= '0;
         second_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         if (fire) begin
            naddr_ff <= naddr_in; daddr_ff <= daddr_in; cact_ff <= cact_in;
            cidx_ff <= cidx_in; lvol_ff <= lvol_in; rvol_ff <= rvol_in;
            pre_ff <= pre_in; cnt_ff <= cnt_in; run_ff <= run_in;
            msk_ff <= msk_in; ovf_ff <= ovf_in; phase_ff <= phase_in;
            second_ff <= second_in;
            ovalid_ff <= 1'b1;
         end else if (rsp_ready) ovalid_ff <= 1'b0;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && !rsp_ready |=> ovalid_ff) else $error("result dropped");
   a_second: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> q_valid) else $error("dual half lost");
   a_mask: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff[0]) |-> !msk_ff[0]) else $error("masked overflow set");

endmodule

### rtl/fm_synth_port_frontend.sv
// fm synth port front end
// req channel: one beat per port access (address write, data write, read,
// timer tick); rsp channel: one beat per result, two for a dual-mode write
// to both chips, last_result marks the final beat of an access.
// csr port: apb-style, chip_mode at 0x0, mixer_enabled at 0x4, pready high.
// a request beat is held in the queue, then its result is registered
// in the output register. throughput: one request per cycle while the
// receiver does not stall; a write to both chips holds its entry for
// a second beat. the output register and state update unit in the back
// end set the rate. a two-entry queue lets the request side keep taking
// beats while the receiver stalls; when it fills, req_ready drops.
// reset: address latches, timers, control chip state cleared, volumes at
// 0xff, both csr registers zero; no clearing pass is needed.
module fm_synth_port_frontend #(
   parameter int CHIP_COUNT = fmsp_pkg::CHIP_COUNT_DEF,
   parameter int SLOW_DIV   = fmsp_pkg::SLOW_DIV_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fmsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fmsp_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [1:0] mode_ff;
   logic       mixer_ff;
   logic       q_valid, q_ready;
   fmsp_pkg::cmd_type q_data;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == fmsp_pkg::CSR_MIXER) ? {31'd0, mixer_ff} : {30'd0, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         mixer_ff <= 1'b0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == fmsp_pkg::CSR_MODE) mode_ff <= pwdata[1:0];
         else mixer_ff <= pwdata[0];
      end
   end

   fmsp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .mode(mode_ff), .mixer(mixer_ff),
      .q_valid, .q_ready, .q_data
   );

   fmsp_back #(.CHIP_COUNT(CHIP_COUNT), .SLOW_DIV(SLOW_DIV)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

### dv/tb_top.sv
module tb_top;

   localparam logic [2:0] ADDR_MODE  = 3'd0;
   localparam logic [2:0] ADDR_MIXER = 3'd4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   fmsp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   fmsp_pkg::rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   fm_synth_port_frontend dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [1:0] mode_q;
   logic mixer_q;
   logic [8:0] norm_addr;
   logic [7:0] dual_addr [2];
   logic ctl_active;
   logic [7:0] ctl_index;
   logic [7:0] vol_left, vol_right;
   logic [7:0] tmr_preset [4];
   logic [7:0] tmr_count [4];
   logic tmr_run [4], tmr_mask [4], tmr_ovf [4];
   int unsigned phase;

   fmsp_pkg::req_type pending_beats [$];
   fmsp_pkg::rsp_type expected_rsps [$];
   int errors = 0;
   int cycles = 0;
   int req_seen = 0;
   int rsp_seen = 0;
   int rx_hold = 0;
   int tx_gap = 0;
   int stall_req = 0;
   int stall_ack = 0;
   bit hold_req = 0;
   bit req_taken = 0;

   function automatic int chip_of(int idx);
      return (idx < fmsp_pkg::CHIP_COUNT_DEF) ? idx : fmsp_pkg::CHIP_COUNT_DEF - 1;
   endfunction

   function automatic void timer_step(int t);
      if (tmr_run[t]) begin
         if (tmr_count[t] == 8'hff) begin
            tmr_count[t] = tmr_preset[t];
            if (!tmr_mask[t]) tmr_ovf[t] = 1'b1;
         end else begin
            tmr_count[t] = tmr_count[t] + 8'd1;
         end
      end
   endfunction

   function automatic void timer_enable(int t, bit on);
      if (on) begin
         if (!tmr_run[t]) begin
            tmr_run[t] = 1'b1;
            tmr_count[t] = tmr_preset[t];
         end
      end else begin
         tmr_run[t] = 1'b0;
      end
   endfunction

   function automatic bit timer_reg_write(int chip, logic [8:0] r, logic [7:0] v);
      int b;
      b = chip_of(chip) * 2;
      if (r == 9'd2) begin
         tmr_preset[b] = v;
         return 1;
      end
      if (r == 9'd3) begin
         tmr_preset[b+1] = v;
         return 1;
      end
      if (r != 9'd4) return 0;
      if (v[7]) begin
         tmr_ovf[b] = 0;
         tmr_ovf[b+1] = 0;
         return 1;
      end
      timer_enable(b, v[0]);
      tmr_mask[b] = v[6];
      if (v[6]) tmr_ovf[b] = 0;
      timer_enable(b + 1, v[1]);
      tmr_mask[b+1] = v[5];
      if (v[5]) tmr_ovf[b+1] = 0;
      return 1;
   endfunction

   function automatic logic [7:0] timer_status(int chip);
      int b;
      logic [7:0] s;
      b = chip_of(chip) * 2;
      s = 8'h00;
      if (tmr_ovf[b]) s |= 8'hc0;
      if (tmr_ovf[b+1]) s |= 8'ha0;
      return s;
   endfunction

   function automatic fmsp_pkg::rsp_type dual_write(int idx, logic [7:0] v);
      fmsp_pkg::rsp_type o;
      logic [7:0] r;
      o = '0;
      r = dual_addr[idx];
      if (r == 8'd5) return o;
      if (r >= 8'he0) v &= 8'h03;
      if (timer_reg_write(idx, {1'b0, r}, v)) return o;
      if (r >= 8'hc0 && r <= 8'hc8) v = (v & 8'h0f) | (idx ? 8'ha0 : 8'h50);
      o.synth_write = 1'b1;
      o.synth_register = {idx[0], r};
      o.synth_value = v;
      return o;
   endfunction

   function automatic void predict_port_access(fmsp_pkg::req_type q);
      fmsp_pkg::rsp_type o, o2;
      bit done;
      logic [15:0] p;
      logic [7:0] v;
      o = '0;
      p = q.port_address;
      v = q.write_data;
      case (q.opcode)
         fmsp_pkg::OP_ADDR: begin
            if (mode_q == fmsp_pkg::MODE_SINGLE) begin
               norm_addr = {1'b0, v};
            end else if (mode_q == fmsp_pkg::MODE_DUAL) begin
               if (!p[3]) dual_addr[p[1]] = v;
               else begin
                  dual_addr[0] = v;
                  dual_addr[1] = v;
               end
            end else begin
               done = 0;
               if (mode_q == fmsp_pkg::MODE_CTRL && p == fmsp_pkg::PORT_CTRL_ADDR) begin
                  if (v == fmsp_pkg::CTRL_ON) begin
                     ctl_active = 1;
                     done = 1;
                  end else if (v == fmsp_pkg::CTRL_OFF) begin
                     ctl_active = 0;
                     done = 1;
                  end else if (ctl_active) begin
                     ctl_index = v;
                     done = 1;
                  end
               end
               if (!done) norm_addr = {p[1], v};
            end
         end
         fmsp_pkg::OP_DATA: begin
            if (mode_q == fmsp_pkg::MODE_DUAL) begin
               if (!p[3]) o = dual_write(int'(p[1]), v);
               else begin
                  o = dual_write(0, v);
                  o2 = dual_write(1, v);
                  expected_rsps.push_back(o);
                  o = o2;
               end
            end else if (mode_q == fmsp_pkg::MODE_CTRL && p == fmsp_pkg::PORT_CTRL_DATA
                         && ctl_active) begin
               if (ctl_index == fmsp_pkg::IDX_LEFT || ctl_index == fmsp_pkg::IDX_RIGHT) begin
                  if (ctl_index == fmsp_pkg::IDX_LEFT) vol_left = v;
                  else vol_right = v;
                  if (mixer_q) begin
                     o.volume_update = 1;
                     o.left_volume = vol_left[4:0];
                     o.right_volume = vol_right[4:0];
                  end
               end
            end else if (!timer_reg_write(0, norm_addr, v)) begin
               o.synth_write = 1;
               o.synth_register = norm_addr;
               o.synth_value = v;
            end
         end
         fmsp_pkg::OP_READ: begin
            if (mode_q == fmsp_pkg::MODE_SINGLE)
               o.read_data = (p[1:0] != 2'b00) ? 8'hff
                             : (timer_status(0) | fmsp_pkg::STATUS_ID);
            else if (mode_q == fmsp_pkg::MODE_DUAL)
               o.read_data = p[0] ? 8'hff
                             : (timer_status(int'(p[1])) | fmsp_pkg::STATUS_ID);
            else if (mode_q == fmsp_pkg::MODE_CTRL && ctl_active
                     && p == fmsp_pkg::PORT_CTRL_ADDR)
               o.read_data = 8'h00;
            else if (mode_q == fmsp_pkg::MODE_CTRL && ctl_active
                     && p == fmsp_pkg::PORT_CTRL_DATA) begin
               case (ctl_index)
                  fmsp_pkg::IDX_ID: o.read_data = fmsp_pkg::CTRL_ID;
                  fmsp_pkg::IDX_LEFT: o.read_data = vol_left;
                  fmsp_pkg::IDX_RIGHT: o.read_data = vol_right;
                  fmsp_pkg::IDX_BASE: o.read_data = fmsp_pkg::CTRL_BASE;
                  default: o.read_data = 8'hff;
               endcase
            end else
               o.read_data = (p[1:0] != 2'b00) ? 8'hff : timer_status(0);
         end
         default: begin
            phase++;
            done = phase >= fmsp_pkg::SLOW_DIV_DEF;
            if (done) phase = 0;
            for (int c = 0; c < fmsp_pkg::CHIP_COUNT_DEF && c < 2; c++) begin
               timer_step(c * 2);
               if (done) timer_step(c * 2 + 1);
            end
         end
      endcase
      o.last_result = 1;
      expected_rsps.push_back(o);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold beat
         end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0 && !hold_req) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
            tx_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                      (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         req_seen <= req_seen + 1;
         predict_port_access(req_data);
      end
   end

   // receiver stall pattern, long hold counted here
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_req != stall_ack) begin
            stall_ack <= stall_req;
            rx_hold <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) < 3)
               rx_hold <= ($urandom_range(0, 14) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(1, 3);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen <= rsp_seen + 1;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected beat expected=none actual=%h", $time, rsp_data);
            errors <= errors + 1;
         end else begin
            fmsp_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            if (e !== rsp_data) begin
               $display("%0t: mismatch expected=%h actual=%h", $time, e, rsp_data);
               errors <= errors + 1;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit after %0d request and %0d result beats",
                  req_seen, rsp_seen);
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] a, logic [31:0] v);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (a == ADDR_MODE) mode_q = v[1:0];
      else mixer_q = v[0];
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic drain_all();
      while (pending_beats.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic fmsp_pkg::req_type beat_of(logic [1:0] op, logic [15:0] p,
                                                 logic [7:0] v);
      fmsp_pkg::req_type q;
      q.opcode = op;
      q.port_address = p;
      q.write_data = v;
      return q;
   endfunction

   function automatic logic [15:0] rand_port();
      int k;
      k = $urandom_range(0, 9);
      if (k < 3) return 16'h0388 | 16'($urandom_range(0, 3));
      if (k < 5) return fmsp_pkg::PORT_CTRL_ADDR + 16'($urandom_range(0, 1));
      if (k < 7) return 16'h0220 | 16'($urandom_range(0, 15));
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] rand_reg();
      int k;
      k = $urandom_range(0, 9);
      if (k < 3) return 8'($urandom_range(2, 5));
      if (k < 4) return 8'hc0 + 8'($urandom_range(0, 9));
      if (k < 5) return 8'he0 | 8'($urandom_range(0, 31));
      if (k < 6) return $urandom_range(0, 1) ? fmsp_pkg::IDX_LEFT : fmsp_pkg::IDX_RIGHT;
      if (k < 7) return $urandom_range(0, 1) ? fmsp_pkg::CTRL_ON : fmsp_pkg::CTRL_OFF;
      return 8'($urandom);
   endfunction

   function automatic void queue_random(int n);
      logic [15:0] p;
      for (int i = 0; i < n; i++) begin
         p = rand_port();
         case ($urandom_range(0, 9))
            0, 1, 2: pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, p, rand_reg()));
            3, 4, 5: pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, p,
                        ($urandom_range(0, 3) == 0) ? 8'(1 << $urandom_range(0, 7))
                                                    : 8'($urandom)));
            6: pending_beats.push_back(beat_of(fmsp_pkg::OP_READ, p, 8'($urandom)));
            default: pending_beats.push_back(beat_of(fmsp_pkg::OP_TICK, p, 8'($urandom)));
         endcase
      end
   endfunction

   initial begin
      logic [1:0] modes [4];
      mode_q = 0; mixer_q = 0; norm_addr = 0;
      dual_addr[0] = 0; dual_addr[1] = 0;
      ctl_active = 0; ctl_index = 0; vol_left = 8'hff; vol_right = 8'hff;
      for (int t = 0; t < 4; t++) begin
         tmr_preset[t] = 0; tmr_count[t] = 0;
         tmr_run[t] = 0; tmr_mask[t] = 0; tmr_ovf[t] = 0;
      end
      phase = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: timers, extremes, bank select
      csr_write(ADDR_MODE, 32'(fmsp_pkg::MODE_SINGLE));
      csr_write(ADDR_MIXER, 32'd0);
      pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, 16'h0388, 8'h02));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, 16'h0389, 8'hfe));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, 16'h0388, 8'h04));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, 16'h0389, 8'h03));
      for (int i = 0; i < 6; i++)
         pending_beats.push_back(beat_of(fmsp_pkg::OP_TICK, 16'hffff, 8'hff));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_READ, 16'h0388, 8'h00));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_READ, 16'h0389, 8'h00));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, 16'h0389, 8'h80));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, 16'hffff, 8'hff));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, 16'h0000, 8'h00));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, 16'h0000, 8'hff));
      drain_all();
      csr_write(ADDR_MODE, 32'(fmsp_pkg::MODE_CTRL));
      csr_write(ADDR_MIXER, 32'd1);
      pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, fmsp_pkg::PORT_CTRL_ADDR,
                                      fmsp_pkg::CTRL_ON));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, fmsp_pkg::PORT_CTRL_ADDR,
                                      fmsp_pkg::IDX_LEFT));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, fmsp_pkg::PORT_CTRL_DATA, 8'h3c));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_READ, fmsp_pkg::PORT_CTRL_DATA, 8'h00));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_READ, fmsp_pkg::PORT_CTRL_ADDR, 8'h00));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, fmsp_pkg::PORT_CTRL_ADDR,
                                      fmsp_pkg::CTRL_OFF));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_ADDR, 16'h038a, 8'h42));
      pending_beats.push_back(beat_of(fmsp_pkg::OP_DATA, 16'h0389, 8'h11));
      drain_all();

      modes[0] = fmsp_pkg::MODE_DUAL; modes[1] = fmsp_pkg::MODE_SINGLE;
      modes[2] = fmsp_pkg::MODE_EXT;  modes[3] = fmsp_pkg::MODE_CTRL;
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(ADDR_MODE, 32'(modes[ph % 4]));
         csr_write(ADDR_MIXER, 32'($urandom_range(0, 1)));
         if (ph == 2) begin
            // long receiver stall while sender keeps offering
            stall_req = stall_req + 1;
            queue_random(30);
         end
         if (ph == 5) begin
            // sender waits for all results before continuing
            queue_random(20);
            drain_all();
            hold_req = 1;
            repeat (40) @(posedge clock);
            hold_req = 0;
         end
         queue_random(130);
         drain_all();
      end

      $display("covered %0d request beats and %0d result beats in all four chip modes",
               req_seen, rsp_seen);
      $display("with timer overflow, volume writes, a long output stall and a drain pause");
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

### fm_synth_port_frontend.f
rtl/fmsp_pkg.sv
rtl/fmsp_front.sv
rtl/fmsp_back.sv
rtl/fm_synth_port_frontend.sv
dv/tb_top.sv
